>>> hw/rtl/plfm_pkg.sv
// Shared types, codes and constants for the price level FIFO matcher.
package plfm_pkg;

  localparam int PLF_QUEUE_DEPTH = 16;
  localparam int MAX_TRADES      = 16;
  localparam int TRD_CNT_W       = 5;
  localparam int TOTAL_W         = 36;
  localparam int IN_TDATA_W      = 136;
  localparam int OUT_TDATA_W     = 264;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_REDUCE = 2'd2,
    FN_MATCH  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_TRADE     = 2'd3
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_NOTFOUND,
    S_HIT,
    S_SHIFT,
    S_DELFIN,
    S_MATCH,
    S_MFILL
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ADD,
    OP_SCAN,
    OP_NOTFOUND,
    OP_DEL_START,
    OP_SHIFT,
    OP_DEL_FIN,
    OP_CUT,
    OP_MEMPTY,
    OP_MREAD,
    OP_MFILL
  } dp_op_t;

  typedef struct packed {
    logic out_free;
    logic scan_hit;
    logic scan_done;
    logic del_sel;
    logic m_empty;
    logic m_last;
  } dp_sts_t;

endpackage

>>> hw/rtl/plfm_dp.sv
// Datapath: order queue memory, pointers, running total and result register.
module plfm_dp import plfm_pkg::*; #(
  parameter int QUEUE_DEPTH = PLF_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [31:0]            cfg_wr_data,
  input  logic [1:0]             in_tuser,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  dp_op_t                 op,
  output dp_sts_t                sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [63:0] mem [QUEUE_DEPTH];

  logic [PW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [31:0]        price_r;
  logic               out_vld_r, out_vld_nxt;
  logic               rd_vld_r, rd_vld_nxt;

  logic [CW-1:0]        scan_r, scan_nxt;
  logic [CW-1:0]        rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]        pos_r, pos_nxt;
  logic [31:0]          posq_r, posq_nxt;
  func_t                func_r, func_nxt;
  logic [31:0]          id_r, id_nxt;
  logic [31:0]          left_r, left_nxt;
  logic                 side_r, side_nxt;
  logic [63:0]          time_r, time_nxt;
  logic [TRD_CNT_W-1:0] ntr_r, ntr_nxt;
  logic [63:0]          rd_data_r;

  logic [1:0]         o_st_r, o_st_nxt;
  logic [31:0]        o_taker_r, o_taker_nxt;
  logic [31:0]        o_maker_r, o_maker_nxt;
  logic               o_side_r, o_side_nxt;
  logic [31:0]        o_price_r, o_price_nxt;
  logic [31:0]        o_fill_r, o_fill_nxt;
  logic [63:0]        o_time_r, o_time_nxt;
  logic [31:0]        o_left_r, o_left_nxt;
  logic [TOTAL_W-1:0] o_total_r, o_total_nxt;
  logic               o_last_r, o_last_nxt;

  logic          mem_we, mem_re;
  logic [PW-1:0] mem_waddr, mem_raddr;
  logic [63:0]   mem_wdata;

  logic [31:0] rd_id, rd_qty, fill, qrem, left_after;
  logic        full;

  // Logical queue index to physical slot of the circular buffer.
  function automatic logic [PW-1:0] phys(input logic [PW-1:0] head,
                                         input logic [CW-1:0] idx);
    logic [CW:0] s;
    s = (CW+1)'(head) + (CW+1)'(idx);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[PW-1:0];
  endfunction

  assign rd_id      = rd_data_r[63:32];
  assign rd_qty     = rd_data_r[31:0];
  assign fill       = (rd_qty < left_r) ? rd_qty : left_r;
  assign qrem       = rd_qty - fill;
  assign left_after = left_r - fill;
  assign full       = (count_r == CW'(QUEUE_DEPTH));

  assign sts.out_free  = !out_vld_r || out_tready;
  assign sts.scan_hit  = rd_vld_r && (rd_id == id_r);
  assign sts.scan_done = !rd_vld_r && (scan_r >= count_r);
  assign sts.del_sel   = (func_r == FN_REMOVE) || (left_r >= posq_r);
  assign sts.m_empty   = (count_r == '0) || (left_r == '0);
  assign sts.m_last    = (left_after == '0) || ((qrem == '0) && (count_r == CW'(1))) ||
                         (ntr_r == TRD_CNT_W'(MAX_TRADES - 1));

  always_comb begin
    logic       emit;
    logic [1:0] e_st;
    logic [31:0] e_taker, e_maker, e_price, e_fill, e_left;
    logic        e_side, e_last;
    logic [63:0] e_time;

    head_nxt    = head_r;
    count_nxt   = count_r;
    total_nxt   = total_r;
    rd_vld_nxt  = rd_vld_r;
    scan_nxt    = scan_r;
    rd_idx_nxt  = rd_idx_r;
    pos_nxt     = pos_r;
    posq_nxt    = posq_r;
    func_nxt    = func_r;
    id_nxt      = id_r;
    left_nxt    = left_r;
    side_nxt    = side_r;
    time_nxt    = time_r;
    ntr_nxt     = ntr_r;
    mem_we      = 1'b0;
    mem_waddr   = phys(head_r, count_r);
    mem_wdata   = {id_r, left_r};
    mem_re      = 1'b0;
    mem_raddr   = phys(head_r, scan_r);
    emit        = 1'b0;
    e_st        = ST_DONE;
    e_taker     = '0;
    e_maker     = '0;
    e_side      = 1'b0;
    e_price     = '0;
    e_fill      = '0;
    e_time      = '0;
    e_left      = '0;
    e_last      = 1'b1;

    unique case (op)
      OP_LOAD: begin
        func_nxt   = func_t'(in_tuser);
        id_nxt     = in_tdata[31:0];
        left_nxt   = in_tdata[63:32];
        side_nxt   = in_tdata[64];
        time_nxt   = in_tdata[128:65];
        scan_nxt   = '0;
        rd_vld_nxt = 1'b0;
        ntr_nxt    = '0;
      end
      OP_ADD: begin
        emit = 1'b1;
        if (full) begin
          e_st = ST_FULL;
        end else begin
          mem_we    = 1'b1;
          count_nxt = count_r + CW'(1);
          total_nxt = total_r + TOTAL_W'(left_r);
        end
      end
      OP_SCAN: begin
        if (sts.scan_hit) begin
          pos_nxt  = rd_idx_r;
          posq_nxt = rd_qty;
        end else if (scan_r < count_r) begin
          mem_re     = 1'b1;
          rd_idx_nxt = scan_r;
          scan_nxt   = scan_r + CW'(1);
          rd_vld_nxt = 1'b1;
        end else begin
          rd_vld_nxt = 1'b0;
        end
      end
      OP_NOTFOUND: begin
        emit = 1'b1;
        e_st = ST_NOT_FOUND;
      end
      OP_DEL_START: begin
        total_nxt  = total_r - TOTAL_W'(posq_r);
        scan_nxt   = pos_r + CW'(1);
        rd_vld_nxt = 1'b0;
      end
      OP_SHIFT: begin
        // Each entry after the deleted one moves down by one slot.
        if (rd_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = phys(head_r, rd_idx_r - CW'(1));
          mem_wdata = rd_data_r;
        end
        if (scan_r < count_r) begin
          mem_re     = 1'b1;
          rd_idx_nxt = scan_r;
          scan_nxt   = scan_r + CW'(1);
          rd_vld_nxt = 1'b1;
        end else begin
          rd_vld_nxt = 1'b0;
        end
      end
      OP_DEL_FIN: begin
        count_nxt = count_r - CW'(1);
        emit      = 1'b1;
      end
      OP_CUT: begin
        mem_we    = 1'b1;
        mem_waddr = phys(head_r, pos_r);
        mem_wdata = {id_r, posq_r - left_r};
        total_nxt = total_r - TOTAL_W'(left_r);
        emit      = 1'b1;
      end
      OP_MEMPTY: begin
        emit    = 1'b1;
        e_taker = id_r;
        e_side  = side_r;
        e_left  = left_r;
      end
      OP_MREAD: begin
        mem_re    = 1'b1;
        mem_raddr = head_r;
      end
      OP_MFILL: begin
        // Prefetch the second entry: it is the new head if this one empties.
        mem_re    = 1'b1;
        mem_raddr = phys(head_r, CW'(1));
        total_nxt = total_r - TOTAL_W'(fill);
        left_nxt  = left_after;
        ntr_nxt   = ntr_r + TRD_CNT_W'(1);
        if (qrem == '0) begin
          head_nxt  = phys(head_r, CW'(1));
          count_nxt = count_r - CW'(1);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = head_r;
          mem_wdata = {rd_id, qrem};
        end
        emit    = 1'b1;
        e_st    = ST_TRADE;
        e_taker = id_r;
        e_maker = rd_id;
        e_side  = side_r;
        e_price = price_r;
        e_fill  = fill;
        e_time  = time_r;
        e_left  = left_after;
        e_last  = sts.m_last;
      end
      default: begin
      end
    endcase

    o_st_nxt    = o_st_r;
    o_taker_nxt = o_taker_r;
    o_maker_nxt = o_maker_r;
    o_side_nxt  = o_side_r;
    o_price_nxt = o_price_r;
    o_fill_nxt  = o_fill_r;
    o_time_nxt  = o_time_r;
    o_left_nxt  = o_left_r;
    o_total_nxt = o_total_r;
    o_last_nxt  = o_last_r;
    out_vld_nxt = out_vld_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
      o_st_nxt    = e_st;
      o_taker_nxt = e_taker;
      o_maker_nxt = e_maker;
      o_side_nxt  = e_side;
      o_price_nxt = e_price;
      o_fill_nxt  = e_fill;
      o_time_nxt  = e_time;
      o_left_nxt  = e_left;
      o_total_nxt = total_nxt;
      o_last_nxt  = e_last;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      count_r   <= '0;
      total_r   <= '0;
      price_r   <= '0;
      out_vld_r <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      total_r   <= total_nxt;
      out_vld_r <= out_vld_nxt;
      rd_vld_r  <= rd_vld_nxt;
      if (cfg_wr_en) begin
        price_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_r    <= scan_nxt;
    rd_idx_r  <= rd_idx_nxt;
    pos_r     <= pos_nxt;
    posq_r    <= posq_nxt;
    func_r    <= func_nxt;
    id_r      <= id_nxt;
    left_r    <= left_nxt;
    side_r    <= side_nxt;
    time_r    <= time_nxt;
    ntr_r     <= ntr_nxt;
    o_st_r    <= o_st_nxt;
    o_taker_r <= o_taker_nxt;
    o_maker_r <= o_maker_nxt;
    o_side_r  <= o_side_nxt;
    o_price_r <= o_price_nxt;
    o_fill_r  <= o_fill_nxt;
    o_time_r  <= o_time_nxt;
    o_left_r  <= o_left_nxt;
    o_total_r <= o_total_nxt;
    o_last_r  <= o_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = o_st_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {3'b000, o_total_r, o_left_r, o_time_r, o_fill_r, o_price_r,
                       o_side_r, o_maker_r, o_taker_r};

endmodule

>>> hw/rtl/plfm_ctrl.sv
// Controller state machine: sequences each request through the datapath.
module plfm_ctrl import plfm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic [1:0] in_tuser,
  output logic       in_tready,
  input  dp_sts_t    sts,
  output dp_op_t     op
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op = OP_LOAD;
          unique case (func_t'(in_tuser)) inside
            FN_ADD:             state_nxt = S_ADD;
            FN_REMOVE, FN_REDUCE: state_nxt = S_SCAN;
            FN_MATCH:           state_nxt = S_MATCH;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (sts.out_free) begin
          op        = OP_ADD;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        op = OP_SCAN;
        if (sts.scan_hit) begin
          state_nxt = S_HIT;
        end else if (sts.scan_done) begin
          state_nxt = S_NOTFOUND;
        end
      end
      S_NOTFOUND: begin
        if (sts.out_free) begin
          op        = OP_NOTFOUND;
          state_nxt = S_IDLE;
        end
      end
      S_HIT: begin
        // A remove, or a cut that covers the entry, deletes it.
        if (sts.del_sel) begin
          op        = OP_DEL_START;
          state_nxt = S_SHIFT;
        end else if (sts.out_free) begin
          op        = OP_CUT;
          state_nxt = S_IDLE;
        end
      end
      S_SHIFT: begin
        op = OP_SHIFT;
        if (sts.scan_done) begin
          state_nxt = S_DELFIN;
        end
      end
      S_DELFIN: begin
        if (sts.out_free) begin
          op        = OP_DEL_FIN;
          state_nxt = S_IDLE;
        end
      end
      S_MATCH: begin
        if (!sts.m_empty) begin
          op        = OP_MREAD;
          state_nxt = S_MFILL;
        end else if (sts.out_free) begin
          op        = OP_MEMPTY;
          state_nxt = S_IDLE;
        end
      end
      S_MFILL: begin
        if (sts.out_free) begin
          op = OP_MFILL;
          if (sts.m_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/price_level_fifo_matcher_top.sv
// Add answers as soon as the output is free; remove and reduce scan the queue from the
// head for the id, then cut the entry in place or delete it and shift each later entry
// down; a match reads the head entry before its first trade. Throughput: one request at a
// time; a match then gives one trade per cycle while the output is free, paced by the
// single read port of the queue memory. A new request is taken while a result waits.
// Reset is synchronous and active low; it empties the queue and clears total and price.
module price_level_fifo_matcher_top import plfm_pkg::*; #(
  parameter int QUEUE_DEPTH = PLF_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [31:0]            cfg_wr_data,  // level_price
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // order_id[31:0], qty[63:32], side[64], exec_time[128:65], zero fill above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,     // func
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // taker_id[31:0], maker_id[63:32], taker_side[64], trade_price[96:65],
  // fill_qty[128:97], trade_time[192:129], taker_left[224:193],
  // level_total[260:225], zero fill above
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser,    // status
  output logic                   out_tlast     // last
);

  dp_op_t  op;
  dp_sts_t sts;

  plfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .op        (op)
  );

  plfm_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .op          (op),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

`ifndef SYNTHESIS
  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while the previous one is in progress");

  // Only trades come in runs; every other result closes its request.
  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_TRADE)) |-> out_tlast)
    else $error("non-trade result without last");

  // While idle, the controller issues no datapath work beyond loading a request.
  a_idle_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (op == OP_NONE || op == OP_LOAD))
    else $error("datapath work issued while idle");
`endif

endmodule

>>> dv/price_level_checker.sv
// Watches the request and result streams of the price level matcher, predicts results and compares.
module price_level_checker import plfm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [31:0]            cfg_wr_data,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [1:0]             out_tuser,
  input  logic                   out_tlast,
  output int                     failures,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    stat_t        status;
    logic [31:0]  taker_id;
    logic [31:0]  maker_id;
    logic         taker_side;
    logic [31:0]  trade_price;
    logic [31:0]  fill_qty;
    logic [63:0]  trade_time;
    logic [31:0]  taker_left;
    logic [35:0]  level_total;
    logic         last;
  } level_result_t;

  // Shadow of the resting orders, head first.
  logic [31:0]   rest_ids[$];
  logic [31:0]   rest_qtys[$];
  logic [35:0]   resting_total;
  logic [31:0]   level_price;
  level_result_t level_results_q[$];

  task automatic predict_level_results(input func_t f, input logic [31:0] id,
                                       input logic [31:0] qty, input logic side,
                                       input logic [63:0] tm);
    level_result_t r;
    int            pos;
    int            n;
    logic [31:0]   left;
    logic [31:0]   fill;
    r = '0;
    r.status = ST_DONE;
    r.last = 1'b1;
    case (f)
      FN_ADD: begin
        if (rest_ids.size() >= PLF_QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          rest_ids = {rest_ids, id};
          rest_qtys = {rest_qtys, qty};
          resting_total = resting_total + {4'b0, qty};
        end
        r.level_total = resting_total;
        level_results_q = {level_results_q, r};
      end
      FN_REMOVE, FN_REDUCE: begin
        pos = -1;
        foreach (rest_ids[i]) begin
          if (pos < 0 && rest_ids[i] == id) pos = i;
        end
        if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (f == FN_REMOVE || qty >= rest_qtys[pos]) begin
          resting_total = resting_total - {4'b0, rest_qtys[pos]};
          rest_ids.delete(pos);
          rest_qtys.delete(pos);
        end else begin
          rest_qtys[pos] = rest_qtys[pos] - qty;
          resting_total = resting_total - {4'b0, qty};
        end
        r.level_total = resting_total;
        level_results_q = {level_results_q, r};
      end
      default: begin
        n = 0;
        left = qty;
        while (rest_ids.size() > 0 && left != 0 && n < MAX_TRADES) begin
          fill = (rest_qtys[0] < left) ? rest_qtys[0] : left;
          left = left - fill;
          rest_qtys[0] = rest_qtys[0] - fill;
          resting_total = resting_total - {4'b0, fill};
          r = '0;
          r.status = ST_TRADE;
          r.taker_id = id;
          r.maker_id = rest_ids[0];
          r.taker_side = side;
          r.trade_price = level_price;
          r.fill_qty = fill;
          r.trade_time = tm;
          r.taker_left = left;
          r.level_total = resting_total;
          if (rest_qtys[0] == 0) begin
            rest_ids.delete(0);
            rest_qtys.delete(0);
          end
          n++;
          r.last = (rest_ids.size() == 0 || left == 0 || n == MAX_TRADES);
          level_results_q = {level_results_q, r};
        end
        // A match that fills nothing still answers once, echoing the taker.
        if (n == 0) begin
          r.taker_id = id;
          r.taker_side = side;
          r.taker_left = qty;
          r.level_total = resting_total;
          level_results_q = {level_results_q, r};
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : watch
    level_result_t want;
    if (!rst_n) begin
      rest_ids.delete();
      rest_qtys.delete();
      level_results_q.delete();
      resting_total = '0;
      level_price = '0;
      failures = 0;
    end else begin
      if (cfg_wr_en) level_price = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        if (level_results_q.size() == 0) begin
          $error("result with status %0d arrived with no request pending", out_tuser);
          failures++;
        end else begin
          want = level_results_q[0];
          level_results_q.delete(0);
          check_field("status", 64'(want.status), 64'(out_tuser));
          check_field("taker_id", 64'(want.taker_id), 64'(out_tdata[31:0]));
          check_field("maker_id", 64'(want.maker_id), 64'(out_tdata[63:32]));
          check_field("taker_side", 64'(want.taker_side), 64'(out_tdata[64]));
          check_field("trade_price", 64'(want.trade_price), 64'(out_tdata[96:65]));
          check_field("fill_qty", 64'(want.fill_qty), 64'(out_tdata[128:97]));
          check_field("trade_time", want.trade_time, out_tdata[192:129]);
          check_field("taker_left", 64'(want.taker_left), 64'(out_tdata[224:193]));
          check_field("level_total", 64'(want.level_total), 64'(out_tdata[260:225]));
          check_field("last", 64'(want.last), 64'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) begin
        predict_level_results(func_t'(in_tuser), in_tdata[31:0], in_tdata[63:32],
                              in_tdata[64], in_tdata[128:65]);
      end
    end
    outstanding <= level_results_q.size();
  end

endmodule

>>> dv/tb_price_level_fifo_matcher_top.sv
// Stimulus and verdict for the price level matcher, with the checker beside the block.
module tb_price_level_fifo_matcher_top;
  timeunit 1ns;
  timeprecision 1ps;
  import plfm_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [31:0]            cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;

  int          failures;
  int          outstanding;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          requests_sent;
  logic [31:0] id_pool[8];

  price_level_fifo_matcher_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  price_level_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .failures   (failures),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Ends the run when neither stream moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_req(input func_t f, input logic [31:0] id, input logic [31:0] qty,
                          input logic side, input logic [63:0] tm);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {7'b0, tm, side, qty, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  // Holds off new requests until every result is back and the block has settled.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_price(input logic [31:0] price);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= price;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [31:0] pick_id();
    if ($urandom_range(99) < 85) return id_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_qty(input int small_max);
    int r;
    r = $urandom_range(99);
    if (r < 8) return 32'h0;
    if (r < 16) return $urandom;
    return $urandom_range(1, small_max);
  endfunction

  task automatic random_request();
    int          r;
    logic [63:0] tm;
    tm = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 3) begin
      // Fill the queue past its depth, then sweep it with one large match.
      repeat (PLF_QUEUE_DEPTH + 1) begin
        send_req(FN_ADD, pick_id(), $urandom_range(1, 20), 1'($urandom_range(1)), tm);
      end
      send_req(FN_MATCH, pick_id(), $urandom, 1'($urandom_range(1)), tm);
    end else if (r < 42) begin
      send_req(FN_ADD, pick_id(), pick_qty(60), 1'($urandom_range(1)), tm);
    end else if (r < 56) begin
      send_req(FN_REMOVE, pick_id(), pick_qty(60), 1'($urandom_range(1)), tm);
    end else if (r < 74) begin
      send_req(FN_REDUCE, pick_id(), pick_qty(40), 1'($urandom_range(1)), tm);
    end else begin
      send_req(FN_MATCH, pick_id(), pick_qty(150), 1'($urandom_range(1)), tm);
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input logic [31:0] price,
                           input int count);
    int target;
    write_price(price);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    target = requests_sent + count;
    while (requests_sent < target) random_request();
    drain_results();
  endtask

  task automatic directed_requests();
    logic [63:0] ones;
    ones = '1;
    send_req(FN_MATCH, 32'h0000_0042, 32'd7, 1'b0, 64'h0);
    send_req(FN_REMOVE, 32'h0000_1234, 32'd0, 1'b0, 64'h0);
    send_req(FN_REDUCE, 32'h0000_1234, 32'd5, 1'b1, ones);
    // Fill past the depth: a zero-quantity entry first, the largest as the last that fits.
    send_req(FN_ADD, 32'hFFFF_FFFF, 32'd0, 1'b1, ones);
    send_req(FN_ADD, 32'h0000_0000, 32'd3, 1'b0, 64'h0);
    for (int i = 2; i < PLF_QUEUE_DEPTH - 1; i++) begin
      send_req(FN_ADD, 32'd100 + i, i + 1, 1'b0, 64'h0);
    end
    send_req(FN_ADD, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 1'b0, 64'h0);
    send_req(FN_ADD, 32'h0000_0007, 32'd9, 1'b0, 64'h0);
    send_req(FN_MATCH, 32'h1357_9BDF, 32'd0, 1'b1, ones);
    send_req(FN_REDUCE, 32'h0000_0000, 32'd0, 1'b0, 64'h0);
    send_req(FN_REDUCE, 32'd102, 32'd1, 1'b0, 64'h0);
    send_req(FN_REDUCE, 32'd103, 32'hFFFF_FFFF, 1'b0, 64'h0);
    send_req(FN_REMOVE, 32'd104, 32'd0, 1'b0, 64'h0);
    send_req(FN_ADD, 32'h5A5A_5A5A, 32'd0, 1'b0, 64'h0);
    send_req(FN_MATCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ones);
    send_req(FN_MATCH, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 64'h0);
    // An entry holding zero is deleted by a zero cut.
    send_req(FN_ADD, 32'h0000_0009, 32'd0, 1'b0, 64'h0);
    send_req(FN_REDUCE, 32'h0000_0009, 32'd0, 1'b0, 64'h0);
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = FN_ADD;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    requests_sent  = 0;
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) id_pool[i] = $urandom;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_price(32'hFFFF_FFFF);
    directed_requests();
    drain_results();
    run_phase(0, 0, $urandom, 100);
    run_phase(84, 0, 32'h0000_0000, 95);
    run_phase(0, 84, 32'h0000_0001, 95);
    run_phase(23, 23, 32'h8000_0000, 95);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
